// ===== rtl/stable_ascending_sorter_defines.svh =====
// Assertion macros shared by the sorter RTL.
`ifndef STABLE_ASCENDING_SORTER_DEFINES_SVH
`define STABLE_ASCENDING_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorter assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorter assertion failed");

`endif

// ===== rtl/ssort_pkg.sv =====
// Shared types and constants for the stable ascending sorter.
package ssort_pkg;

	localparam int CAPACITY_D    = 64;
	localparam int VALUE_WIDTH_D = 32;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} st_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic pop;
	} ctrl_t;

endpackage

// ===== rtl/ssort_if.sv =====
// Valid/ready channel interfaces for sample input and sorted result output.
interface ssort_in_if import ssort_pkg::*; #(
	parameter int W = VALUE_WIDTH_D
);
	logic         valid;
	logic         ready;
	logic [W-1:0] in_value;
	logic         in_last;

	modport source (output valid, output in_value, output in_last, input ready);
	modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface ssort_out_if import ssort_pkg::*; #(
	parameter int W = VALUE_WIDTH_D
);
	logic         valid;
	logic         ready;
	logic [W-1:0] out_value;
	logic         out_last;
	logic         overflow;

	modport source (output valid, output out_value, output out_last, output overflow,
		input ready);
	modport sink   (input valid, input out_value, input out_last, input overflow,
		output ready);
endinterface

// ===== rtl/stable_ascending_sorter.sv =====
// Samples are accepted back to back during fill; the first sorted result is valid
// in the cycle after the closing transaction, then one result per cycle while
// result.ready stays high. Fill and drain share the single shift path of the
// insertion chain, so no new set is taken until the last one has been drained.
// Reset clears every cell's valid bit, the overflow flag and the state at once;
// there is no clearing pass, and stored values themselves are not reset.
`include "stable_ascending_sorter_defines.svh"

module stable_ascending_sorter import ssort_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_D,
	parameter int VALUE_WIDTH = VALUE_WIDTH_D
) (
	input  logic         clk,
	input  logic         arst_n,
	ssort_in_if.sink     sample,
	ssort_out_if.source  result
);

	st_t                    state_q;
	st_t                    state_nxt;
	ctrl_t                  ctrl;
	logic                   ovf_q;
	logic                   in_acc;
	logic                   out_acc;
	logic                   full;
	logic [CAPACITY-1:0]    cell_valid;
	logic [CAPACITY-1:0]    cell_ins;
	logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];

	assign in_acc  = sample.valid && sample.ready;
	assign out_acc = result.valid && result.ready;
	assign full    = cell_valid[CAPACITY-1];

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		logic [VALUE_WIDTH-1:0] lv;
		logic                   lval;
		logic                   lins;
		logic [VALUE_WIDTH-1:0] rv;
		logic                   rval;

		if (gi == 0) begin : g_first
			assign lv   = '0;
			assign lval = 1'b0;
			assign lins = 1'b0;
		end else begin : g_mid
			assign lv   = cell_value[gi-1];
			assign lval = cell_valid[gi-1];
			assign lins = cell_ins[gi-1];
		end

		if (gi == CAPACITY - 1) begin : g_end
			assign rv   = '0;
			assign rval = 1'b0;
		end else begin : g_inner
			assign rv   = cell_value[gi+1];
			assign rval = cell_valid[gi+1];
		end

		ssort_cell #(
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (sample.in_value),
			.left_value  (lv),
			.left_valid  (lval),
			.left_ins    (lins),
			.right_value (rv),
			.right_valid (rval),
			.value_q     (cell_value[gi]),
			.valid_q     (cell_valid[gi]),
			.ins         (cell_ins[gi])
		);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_FILL: begin
				if (in_acc && sample.in_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_acc && result.out_last) begin
					state_nxt = ST_FILL;
				end
			end
			default: state_nxt = ST_FILL;
		endcase
	end

	always_comb begin
		sample.ready = (state_q == ST_FILL);
		result.valid = (state_q == ST_DRAIN);
		// A sample that arrives with the chain full is dropped.
		ctrl.insert  = in_acc && !full;
		ctrl.pop     = out_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (in_acc && full) begin
			ovf_q <= 1'b1;
		end else if (out_acc && result.out_last) begin
			ovf_q <= 1'b0;
		end
	end

	assign result.out_value = cell_value[0];
	assign result.out_last  = !cell_valid[1];
	assign result.overflow  = ovf_q;

	`SS_ASSERT_NOW(a_drain_has_data, result.valid, cell_valid[0])
	`SS_ASSERT_NOW(a_valid_contiguous, cell_valid[1], cell_valid[0])
	`SS_ASSERT_NXT(a_set_done_empty, out_acc && result.out_last, !cell_valid[0] && sample.ready)
	`SS_ASSERT_NXT(a_insert_lands, ctrl.insert, cell_valid[0])
	`SS_ASSERT_NXT(a_drop_flags, in_acc && full, ovf_q)

endmodule

// ===== rtl/ssort_cell.sv =====
// One cell of the systolic insertion chain: holds one value and its valid bit.
module ssort_cell import ssort_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_D
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_t                  ctrl,
	input  logic [VALUE_WIDTH-1:0] new_value,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic                   left_valid,
	input  logic                   left_ins,
	input  logic [VALUE_WIDTH-1:0] right_value,
	input  logic                   right_valid,
	output logic [VALUE_WIDTH-1:0] value_q,
	output logic                   valid_q,
	output logic                   ins
);

	logic gt;

	// Strictly greater keeps equal values in arrival order.
	assign gt  = valid_q && ($signed(value_q) > $signed(new_value));
	assign ins = gt || !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.insert) begin
			if (left_ins) begin
				valid_q <= left_valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			value_q <= right_value;
		end else if (ctrl.insert) begin
			if (left_ins) begin
				value_q <= left_value;
			end else if (ins) begin
				value_q <= new_value;
			end
		end
	end

endmodule
